FILE: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority ready queue
// Entry layout, command and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int ID_W     = 8;
    localparam int PRIO_W   = 8;
    localparam int OCC_W    = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_POP   = 2'd1,
        OP_EJECT = 2'd2,
        OP_CLEAR = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // broadcast to every cell, update flags already qualified
    typedef struct packed {
        logic   put;
        logic   pop;
        logic   eject;
        t_entry key;
    } t_cell_ctl;

endpackage

FILE: rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry, compares it with the broadcast key and takes its next
// value from itself, the key, or one of its two neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occ,
    input  spq_pkg::t_entry    i_lower,
    input  logic               i_lower_ge,
    input  spq_pkg::t_entry    i_upper,
    input  logic               i_above_match,
    output spq_pkg::t_entry    o_entry,
    output logic               o_ge,
    output logic               o_match_chain,
    output logic               o_sel
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;
    logic            match;

    assign o_entry       = r_entry;
    assign o_ge          = i_occ && (r_entry.prio >= i_ctl.key.prio);
    assign match         = i_occ && (r_entry.id == i_ctl.key.id);
    assign o_match_chain = match || i_above_match;
    assign o_sel         = match && !i_above_match;

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.put) begin
            if (o_ge) begin
                n_entry = r_entry;
            end else if (i_lower_ge) begin
                n_entry = i_ctl.key;
            end else begin
                n_entry = i_lower;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_upper;
        end else if (i_ctl.eject) begin
            // cells at or past the ejected one close up the gap
            if (!i_above_match) begin
                n_entry = i_upper;
            end
        end else begin
            // no update this cycle
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

FILE: rtl/core/sorted_priority_ready_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_ready_queue: bounded ready queue sorted by priority
// Row of compare-and-shift cells holding (thread id, priority) entries.
// ----------------------------------------------------------------------------
// A command is taken on any cycle with start high (busy is always low), one
// command per clock. Its result word appears on the result ports for exactly
// one cycle, marked by o_valid, in the cycle after the command; the receiver
// must take it then. The next command already sees the updated queue, so the
// rate is one command per cycle; each cell of the row compares against the
// broadcast key and loads from itself or a neighbor. Put on a full queue is
// dropped with status full; pop on an empty queue and eject without a match
// return status none with zero data.
// Equal priorities leave in arrival order.
`timescale 1ns / 1ps

module sorted_priority_ready_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_opcode,
    input  logic [spq_pkg::ID_W-1:0]    i_thread_id,
    input  logic [spq_pkg::PRIO_W-1:0]  i_prio,
    output logic                        o_valid,
    output logic [1:0]                  o_status,
    output logic [spq_pkg::ID_W-1:0]    o_out_thread_id,
    output logic [spq_pkg::PRIO_W-1:0]  o_out_prio,
    output logic [spq_pkg::OCC_W-1:0]   o_occupancy
);

    localparam int N = spq_pkg::CAPACITY;

    // cell 0 holds the highest priority, occupied cells are 0 .. count-1
    logic [spq_pkg::CNT_W-1:0] r_count;
    logic [spq_pkg::CNT_W-1:0] n_count;

    logic                     r_valid;
    spq_pkg::t_status         r_status;
    spq_pkg::t_entry          r_data;
    spq_pkg::t_status         n_status;
    spq_pkg::t_entry          n_data;

    spq_pkg::t_opcode         op;
    spq_pkg::t_cell_ctl       ctl;
    logic                     full;
    logic                     empty;
    logic                     found;
    spq_pkg::t_entry          eject_data;

    logic [N-1:0]             occ;
    logic [N-1:0]             ge;
    logic [N-1:0]             match_chain;
    logic [N-1:0]             sel;
    spq_pkg::t_entry          entry [N];

    assign busy  = 1'b0;  // the queue never stalls a command
    assign op    = spq_pkg::t_opcode'(i_opcode);
    assign full  = (r_count == spq_pkg::CNT_W'(N));
    assign empty = (r_count == '0);
    assign found = match_chain[0];  // some occupied cell matches the id

    always_comb begin
        ctl.key.id   = i_thread_id;
        ctl.key.prio = i_prio;
        ctl.put      = start && (op == spq_pkg::OP_PUT) && !full;
        ctl.pop      = start && (op == spq_pkg::OP_POP) && !empty;
        ctl.eject    = start && (op == spq_pkg::OP_EJECT) && found;
    end

    // occupancy of each cell follows from the count alone
    always_comb begin
        for (int k = 0; k < N; k++) begin
            occ[k] = (r_count > spq_pkg::CNT_W'(k));
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            spq_pkg::t_entry lower;
            spq_pkg::t_entry upper;
            logic            lower_ge;
            logic            above;

            if (g == 0) begin : g_first
                assign lower    = '0;
                assign lower_ge = 1'b1;  // a new entry may always land at the head
            end else begin : g_mid_lo
                assign lower    = entry[g-1];
                assign lower_ge = ge[g-1];
            end

            if (g == N - 1) begin : g_last
                assign upper = '0;
                assign above = 1'b0;
            end else begin : g_mid_hi
                assign upper = entry[g+1];
                assign above = match_chain[g+1];
            end

            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (ctl),
                .i_occ         (occ[g]),
                .i_lower       (lower),
                .i_lower_ge    (lower_ge),
                .i_upper       (upper),
                .i_above_match (above),
                .o_entry       (entry[g]),
                .o_ge          (ge[g]),
                .o_match_chain (match_chain[g]),
                .o_sel         (sel[g])
            );
        end
    endgenerate

    // sel is one-hot: the highest-index match, i.e. the lowest priority one
    always_comb begin
        eject_data = '0;
        for (int k = 0; k < N; k++) begin
            eject_data = eject_data | (sel[k] ? entry[k] : '0);
        end
    end

    // result word and next count
    always_comb begin
        n_count  = r_count;
        n_status = spq_pkg::ST_OK;
        n_data   = '0;
        unique case (op)
            spq_pkg::OP_PUT: begin
                if (full) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            spq_pkg::OP_POP: begin
                if (empty) begin
                    n_status = spq_pkg::ST_NONE;
                end else begin
                    n_count = r_count - 1'b1;
                    n_data  = entry[0];
                end
            end
            spq_pkg::OP_EJECT: begin
                if (!found) begin
                    n_status = spq_pkg::ST_NONE;
                end else begin
                    n_count = r_count - 1'b1;
                    n_data  = eject_data;
                end
            end
            spq_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= start;
            if (start) begin
                r_count <= n_count;
            end
        end
    end

    // result payload, qualified by r_valid
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_status <= n_status;
            r_data   <= n_data;
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_out_thread_id = r_data.id;
    assign o_out_prio      = r_data.prio;
    assign o_occupancy     = spq_pkg::OCC_W'(r_count);

    // count stays within the row
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spq_pkg::CNT_W'(N))
        else $error("queue count beyond capacity");

    // one result word per command, in the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> o_valid)
        else $error("missing result strobe");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |=> !o_valid)
        else $error("result strobe without command");

    // accepted put grows the queue by one
    a_put_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && (op == spq_pkg::OP_PUT) && !full)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("put did not add an entry");

    // pop on an empty queue reports none with a zero thread id
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && (op == spq_pkg::OP_POP) && empty)
        |=> (o_status == spq_pkg::ST_NONE) && (o_out_thread_id == '0))
        else $error("empty pop returned data");

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the sorted priority ready queue
// Sends put, pop, eject and clear words through the start/busy handshake,
// keeps its own sorted copy of the queue to predict every result word, and
// compares each strobed result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import spq_pkg::*;

    // one predicted result word
    typedef struct {
        t_status           status;
        logic [ID_W-1:0]   thread_id;
        logic [PRIO_W-1:0] prio;
        logic [OCC_W-1:0]  occupancy;
    } t_result_word;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    logic [1:0]        i_opcode    = OP_CLEAR;
    logic [ID_W-1:0]   i_thread_id = '0;
    logic [PRIO_W-1:0] i_prio      = '0;
    logic              o_valid;
    logic [1:0]        o_status;
    logic [ID_W-1:0]   o_out_thread_id;
    logic [PRIO_W-1:0] o_out_prio;
    logic [OCC_W-1:0]  o_occupancy;

    // shadow of the queue: slot 0 lowest priority, slot held_count-1 highest
    logic [ID_W-1:0]   held_id   [CAPACITY];
    logic [PRIO_W-1:0] held_prio [CAPACITY];
    int                held_count = 0;

    t_result_word      pending_results[$];
    int                mismatch_count  = 0;
    int                sender_idle_pct = 0;

    sorted_priority_ready_queue i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_thread_id     (i_thread_id),
        .i_prio          (i_prio),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_out_thread_id (o_out_thread_id),
        .o_out_prio      (o_out_prio),
        .o_occupancy     (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop in case the handshake or the result strobe hangs
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // applies one command to the shadow queue and returns the word it yields
    function automatic t_result_word apply_queue_op(input t_opcode op,
                                                    input logic [ID_W-1:0] id,
                                                    input logic [PRIO_W-1:0] prio);
        t_result_word r;
        int           slot;
        r.status    = ST_OK;
        r.thread_id = '0;
        r.prio      = '0;
        case (op)
            OP_PUT: begin
                if (held_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    // new entry goes below every entry of equal or higher priority
                    slot = held_count;
                    while (slot > 0 && prio <= held_prio[slot-1]) begin
                        held_id[slot]   = held_id[slot-1];
                        held_prio[slot] = held_prio[slot-1];
                        slot--;
                    end
                    held_id[slot]   = id;
                    held_prio[slot] = prio;
                    held_count++;
                end
            end
            OP_POP: begin
                if (held_count == 0) begin
                    r.status = ST_NONE;
                end else begin
                    held_count--;
                    r.thread_id = held_id[held_count];
                    r.prio      = held_prio[held_count];
                end
            end
            OP_EJECT: begin
                // first match scanning up from the lowest slot
                slot = 0;
                while (slot < held_count && held_id[slot] != id)
                    slot++;
                if (slot >= held_count) begin
                    r.status = ST_NONE;
                end else begin
                    r.thread_id = held_id[slot];
                    r.prio      = held_prio[slot];
                    for (int k = slot; k + 1 < held_count; k++) begin
                        held_id[k]   = held_id[k+1];
                        held_prio[k] = held_prio[k+1];
                    end
                    held_count--;
                end
            end
            default: begin
                held_count = 0;
            end
        endcase
        r.occupancy = OCC_W'(held_count);
        return r;
    endfunction

    // one command word through the start/busy handshake, with random idle gaps
    task automatic send_word(input t_opcode op, input logic [ID_W-1:0] id,
                             input logic [PRIO_W-1:0] prio);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            start       <= 1'b0;
            // junk on the fields while start is low
            i_opcode    <= 2'($urandom_range(3));
            i_thread_id <= ID_W'($urandom_range(255));
            i_prio      <= PRIO_W'($urandom_range(255));
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        start       <= 1'b1;
        i_opcode    <= op;
        i_thread_id <= id;
        i_prio      <= prio;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(apply_queue_op(op, id, prio));
    endtask

    // holds the sender off until every predicted word has come back, or a guard runs out
    task automatic wait_all_results();
        int guard;
        guard = 0;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0 && guard < 100) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    task automatic check_field(input string field, input int expected_val,
                               input int actual_val, input logic bad);
        if (bad) begin
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, field, expected_val, actual_val);
            mismatch_count++;
        end
    endtask

    // every strobed result word against the oldest prediction
    always @(posedge i_clk) begin : check_result_words
        t_result_word exp_word;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word with none expected: status %0d id %0d prio %0d occ %0d",
                         $time, o_status, o_out_thread_id, o_out_prio, o_occupancy);
                mismatch_count++;
            end else begin
                exp_word = pending_results.pop_front();
                check_field("valid", 1, o_valid, o_valid !== 1'b1);
                check_field("status", exp_word.status, o_status,
                            o_status !== exp_word.status);
                check_field("thread id", exp_word.thread_id, o_out_thread_id,
                            o_out_thread_id !== exp_word.thread_id);
                check_field("prio", exp_word.prio, o_out_prio,
                            o_out_prio !== exp_word.prio);
                check_field("occupancy", exp_word.occupancy, o_occupancy,
                            o_occupancy !== exp_word.occupancy);
            end
        end
    end

    // pop, eject and clear on a queue that holds nothing
    task automatic test_empty_queue();
        send_word(OP_POP, 8'h00, 8'h00);
        send_word(OP_EJECT, 8'hFF, 8'hFF);
        send_word(OP_CLEAR, 8'h00, 8'h00);
    endtask

    // fill to capacity with ties and repeated ids, then one put too many
    task automatic test_fill_and_overflow();
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        for (int k = 0; k < CAPACITY; k++) begin
            id   = (k == 1) ? 8'hFF : ID_W'(k % 12);
            prio = PRIO_W'((k % 4) * 85);
            send_word(OP_PUT, id, prio);
        end
        send_word(OP_PUT, 8'hAA, 8'h55);
    endtask

    // eject of a repeated id, eject with no match, pops, clear, pop after clear
    task automatic test_eject_and_clear();
        send_word(OP_EJECT, 8'h00, 8'h00);
        send_word(OP_EJECT, 8'h77, 8'h00);
        send_word(OP_POP, 8'h00, 8'h00);
        send_word(OP_POP, 8'h00, 8'h00);
        send_word(OP_CLEAR, 8'hFF, 8'hFF);
        send_word(OP_POP, 8'h00, 8'h00);
    endtask

    // mixed traffic; put_weight steers how often the queue runs full
    task automatic test_random_traffic(input int n_words, input int idle_pct,
                                       input int put_weight);
        t_opcode           op;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        int                roll;
        sender_idle_pct = idle_pct;
        for (int n = 0; n < n_words; n++) begin
            roll = $urandom_range(99);
            if (roll < put_weight)
                op = OP_PUT;
            else if (roll < 97)
                op = ($urandom_range(1) == 0) ? OP_POP : OP_EJECT;
            else
                op = OP_CLEAR;
            // small id pool makes repeated ids likely
            id = ($urandom_range(3) == 0) ? ID_W'($urandom_range(255))
                                          : ID_W'($urandom_range(7));
            case ($urandom_range(3))
                0:       prio = PRIO_W'($urandom_range(3));
                1:       prio = PRIO_W'(255 - $urandom_range(3));
                default: prio = PRIO_W'($urandom_range(255));
            endcase
            // ejects mostly hit an entry that is held
            if (op == OP_EJECT && held_count > 0 && $urandom_range(4) != 0)
                id = held_id[$urandom_range(held_count - 1)];
            send_word(op, id, prio);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_fill_and_overflow();
        test_eject_and_clear();
        wait_all_results();

        test_random_traffic(200, 0, 45);
        wait_all_results();
        test_random_traffic(200, 71, 50);
        test_random_traffic(180, 24, 45);
        wait_all_results();
        // put heavy, keeps the queue near and at capacity
        test_random_traffic(150, 0, 70);
        wait_all_results();

        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, pending_results.size());
            mismatch_count += pending_results.size();
        end
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_ready_queue.sv
tb/tb.sv
